@@ src/bzr_pkg.sv @@
// shared types, codes and constants of the buzzer tone and melody sequencer
package bzr_pkg;

   // number of notes, each with its own period register
   localparam int NumNotes = 4;
   localparam int NoteWidth = $clog2(NumNotes);
   localparam int PeriodWidth = 8;
   localparam int CsrAddrWidth = NoteWidth + 2;
   localparam int CsrDataWidth = 32;

   // operation codes of an input item
   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_PLAY = 3'd1;
   localparam logic [2:0] OP_TOGGLE = 3'd2;
   localparam logic [2:0] OP_AUDIO_OFF = 3'd3;
   localparam logic [2:0] OP_NEXT_NOTE = 3'd4;

   // melody kinds
   localparam logic [1:0] KIND_INTRO = 2'd0;
   localparam logic [1:0] KIND_DURING = 2'd1;
   localparam logic [1:0] KIND_WIN = 2'd2;
   localparam logic [1:0] KIND_LOSE = 2'd3;

   typedef logic [NumNotes-1:0][PeriodWidth-1:0] period_array_type;

   // period register reset values, note 0 in the lowest slot
   localparam period_array_type PeriodReset = {8'd10, 8'd8, 8'd6, 8'd4};

   // input item, operation in the lowest bits
   typedef struct packed {
      logic [9:0] tempo_sample;
      logic [1:0] melody_kind;
      logic [2:0] operation;
   } req_item_type;

   // result item, audio_pin in the lowest bit
   typedef struct packed {
      logic                 toggle_turned_on;
      logic [NoteWidth-1:0] current_note;
      logic                 melody_busy;
      logic                 audio_enabled;
      logic                 audio_pin;
   } rsp_item_type;

endpackage

@@ src/buzzer_tone_melody_sequencer_top.sv @@
// top level of the buzzer tone generator and melody sequencer
//
//   channel  direction  handshake          payload
//   req      in         tvalid / tready    tdata: operation, melody_kind, tempo_sample
//   rsp      out        tvalid / tready    tdata: audio_pin .. toggle_turned_on
//   csr      in         apb, pready high   four 8-bit period registers at 0x0..0xc
//
// an item's result is offered after it passes the input register, then the state update
// into the result register; one item per cycle sustained while results are taken
// reset is synchronous; audio starts off with the pin high, periods 4, 6, 8, 10
// a stalled result holds; the input register still takes one more item,
// then req_tready drops until the result is taken
module buzzer_tone_melody_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] operation, [4:3] melody_kind, [14:5] tempo_sample, [15] zero
   input  logic [15:0]                       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] audio_pin, [1] audio_enabled, [2] melody_busy, [4:3] current_note,
   // [5] toggle_turned_on, [7:6] zero
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bzr_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bzr_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [bzr_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import bzr_pkg::*;

   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;
   rsp_item_type     next_result;
   period_array_type periods;
   logic             advance;
   logic             req_fire;

   // handshake control
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_tdata[$bits(req_item_type)-1:0];
      end
   end

   bzr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .periods     (periods)
   );

   bzr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_item_ff),
      .periods (periods),
      .result  (next_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= next_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(8 - $bits(rsp_item_type)){1'b0}}, rsp_item_ff};

`ifndef SYNTHESIS
   // an item leaving the input register always shows up as a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");
   // back pressure on the input only when the input register holds an item
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a waiting result");
   // an unread result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result overwritten before it was taken");
`endif

endmodule

@@ src/bzr_csr.sv @@
// period registers behind the apb-style configuration port
module bzr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bzr_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bzr_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [bzr_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready,
   output bzr_pkg::period_array_type         periods
);
   import bzr_pkg::*;

   period_array_type period_ff;
   logic [NoteWidth-1:0] reg_sel;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel = csr_paddr[CsrAddrWidth-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
      end else if (wr_en) begin
         period_ff[reg_sel] <= csr_pwdata[PeriodWidth-1:0];
      end
   end

   // read back
   assign csr_prdata = {{(CsrDataWidth-PeriodWidth){1'b0}}, period_ff[reg_sel]};
   assign periods = period_ff;

endmodule

@@ src/bzr_seq.sv @@
// tone generator and melody sequencer state with its combinational update logic
module bzr_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  bzr_pkg::req_item_type      item,
   input  bzr_pkg::period_array_type  periods,
   output bzr_pkg::rsp_item_type      result
);
   import bzr_pkg::*;

   // tone machine codes
   localparam logic [1:0] TONE_RAISE = 2'd0;
   localparam logic [1:0] TONE_LOWER = 2'd1;
   localparam logic [1:0] TONE_OFF = 2'd2;

   logic [1:0]           tone_state_ff, tone_state_in, mid_state;
   logic [7:0]           tone_count_ff, tone_count_in, tone_inc;
   logic [11:0]          tempo_count_ff, tempo_count_in, tempo_inc, limit;
   logic [NoteWidth-1:0] note_index_ff, note_index_in, step;
   logic                 active_ff, active_in;
   logic [1:0]           sel_ff, sel_in;
   logic [1:0]           played_ff, played_in;
   logic                 pin_ff, pin_in;
   logic                 toggle_on_ff, toggle_on_in;

   // saturating counters, note length limit and note step
   assign tone_inc = (tone_count_ff != 8'hFF) ? tone_count_ff + 8'd1 : tone_count_ff;
   assign tempo_inc = (tempo_count_ff != 12'hFFF) ? tempo_count_ff + 12'd1 : tempo_count_ff;
   assign limit = {2'b00, item.tempo_sample} + {1'b0, item.tempo_sample, 1'b0} + 12'd400;
   assign step = (sel_ff == KIND_INTRO) ? NoteWidth'(1) :
                 (sel_ff == KIND_DURING) ? NoteWidth'(2) : NoteWidth'(3);

   // next state for the item in the input register
   always_comb begin
      tone_state_in = tone_state_ff;
      tone_count_in = tone_count_ff;
      tempo_count_in = tempo_count_ff;
      note_index_in = note_index_ff;
      active_in = active_ff;
      sel_in = sel_ff;
      played_in = played_ff;
      pin_in = pin_ff;
      toggle_on_in = toggle_on_ff;
      mid_state = tone_state_ff;
      unique case (item.operation)
         OP_TICK: begin
            tone_count_in = tone_inc;
            tempo_count_in = tempo_inc;
            // square wave: flip the pin at the half period of the note
            if (tone_state_ff != TONE_OFF && tone_inc >= periods[note_index_ff]) begin
               tone_count_in = 8'd0;
               pin_in = (tone_state_ff == TONE_RAISE);
               tone_state_in = (tone_state_ff == TONE_RAISE) ? TONE_LOWER : TONE_RAISE;
            end
            // note advance once the note length has run out
            if (active_ff && tempo_inc >= limit) begin
               note_index_in = note_index_ff + step;
               played_in = played_ff + 2'd1;
               tempo_count_in = 12'd0;
               if (played_ff == 2'd2) begin
                  active_in = 1'b0;
                  if (tone_state_in == TONE_OFF) begin
                     tone_state_in = TONE_RAISE;
                     toggle_on_in = 1'b1;
                  end else begin
                     tone_state_in = TONE_OFF;
                     pin_in = 1'b0;
                     toggle_on_in = 1'b0;
                  end
               end
            end
         end
         OP_PLAY: begin
            // during melody is dropped while another one plays
            if (!(item.melody_kind == KIND_DURING && active_ff)) begin
               mid_state = (item.melody_kind == KIND_WIN || item.melody_kind == KIND_LOSE)
                           ? TONE_OFF : tone_state_ff;
               active_in = 1'b1;
               sel_in = item.melody_kind;
               played_in = 2'd0;
               tempo_count_in = 12'd0;
               if (mid_state == TONE_OFF) begin
                  tone_state_in = TONE_RAISE;
                  toggle_on_in = 1'b1;
               end else begin
                  tone_state_in = TONE_OFF;
                  pin_in = 1'b0;
                  toggle_on_in = 1'b0;
               end
               note_index_in = (item.melody_kind == KIND_LOSE) ?
                               NoteWidth'(NumNotes - 1) : '0;
            end
         end
         OP_TOGGLE: begin
            if (tone_state_ff == TONE_OFF) begin
               tone_state_in = TONE_RAISE;
               toggle_on_in = 1'b1;
            end else begin
               tone_state_in = TONE_OFF;
               pin_in = 1'b0;
               toggle_on_in = 1'b0;
            end
         end
         OP_AUDIO_OFF: begin
            tone_state_in = TONE_OFF;
         end
         OP_NEXT_NOTE: begin
            note_index_in = note_index_ff + NoteWidth'(1);
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_state_ff <= TONE_OFF;
         tone_count_ff <= 8'd0;
         tempo_count_ff <= 12'd0;
         note_index_ff <= '0;
         active_ff <= 1'b0;
         sel_ff <= KIND_INTRO;
         played_ff <= 2'd0;
         pin_ff <= 1'b1;
         toggle_on_ff <= 1'b0;
      end else if (fire) begin
         tone_state_ff <= tone_state_in;
         tone_count_ff <= tone_count_in;
         tempo_count_ff <= tempo_count_in;
         note_index_ff <= note_index_in;
         active_ff <= active_in;
         sel_ff <= sel_in;
         played_ff <= played_in;
         pin_ff <= pin_in;
         toggle_on_ff <= toggle_on_in;
      end
   end

   // result fields after the update
   assign result.audio_pin = pin_in;
   assign result.audio_enabled = (tone_state_in != TONE_OFF);
   assign result.melody_busy = active_in;
   assign result.current_note = note_index_in;
   assign result.toggle_turned_on = toggle_on_in;

`ifndef SYNTHESIS
   // a toggle from the off state enables audio and reports it
   a_toggle_on: assert property (@(posedge clock) disable iff (reset)
      fire && item.operation == OP_TOGGLE && tone_state_ff == TONE_OFF
      |=> toggle_on_ff && tone_state_ff == TONE_RAISE)
      else $error("toggle from off did not enable audio");
   // audio off always lands in the off state
   a_audio_off: assert property (@(posedge clock) disable iff (reset)
      fire && item.operation == OP_AUDIO_OFF |=> tone_state_ff == TONE_OFF)
      else $error("audio off did not stop the tone");
   // the melody stops on its third note
   a_melody_end: assert property (@(posedge clock) disable iff (reset)
      active_ff && fire && played_in == 2'd3 && played_ff == 2'd2 |=> !active_ff)
      else $error("melody kept playing after its third note");
`endif

endmodule
